@@ rtl/ppurp_pkg.sv @@
`timescale 1ns / 1ps

package ppurp_pkg;

    localparam logic [9:0]  DOTS_PER_LINE   = 10'd341;
    localparam logic [8:0]  LINES_PER_FRAME = 9'd262;
    localparam logic [8:0]  VBLANK_LINE     = 9'd241;

    localparam logic [1:0]  MODE_READ  = 2'd0;
    localparam logic [1:0]  MODE_WRITE = 2'd1;
    localparam logic [1:0]  MODE_TICK  = 2'd2;

    localparam logic [2:0]  REG_CTRL     = 3'd0;
    localparam logic [2:0]  REG_MASK     = 3'd1;
    localparam logic [2:0]  REG_STATUS   = 3'd2;
    localparam logic [2:0]  REG_OAM_ADDR = 3'd3;
    localparam logic [2:0]  REG_OAM_DATA = 3'd4;
    localparam logic [2:0]  REG_SCROLL   = 3'd5;
    localparam logic [2:0]  REG_ADDR     = 3'd6;
    localparam logic [2:0]  REG_DATA     = 3'd7;

    localparam logic [13:0] PAL_BASE      = 14'h3F00;
    localparam logic [13:0] PAL_FOLD_LO   = 14'h3F20;
    localparam logic [13:0] PAL_FOLD_HI   = 14'h3FFF;
    localparam logic [13:0] NAME_BASE     = 14'h2000;
    localparam logic [13:0] UNSUP_LO      = 14'h3000;
    localparam logic [13:0] UNSUP_HI      = 14'h3EFF;
    localparam logic [13:0] PAL_MIRROR    = 14'h0010;
    localparam logic [7:0]  SCROLL_V_MAX  = 8'd240;
    localparam logic [8:0]  DRAW_LINE_MAX = 9'd240;
    localparam logic [8:0]  SPRITE0_OFS   = 9'd7;

    typedef struct packed {
        logic        unsupported;
        logic [13:0] video_address;
        logic [8:0]  scanline;
        logic        draw_line;
        logic        frame_done;
        logic        nmi_level;
        logic [7:0]  read_data;
    } t_result;

    function automatic logic [13:0] fold_palette(input logic [13:0] a);
        logic [13:0] f;
        f = a;
        if (a >= PAL_FOLD_LO && a <= PAL_FOLD_HI) begin
            f = PAL_BASE | {9'd0, a[4:0]};
        end
        return f;
    endfunction

    function automatic logic [12:0] store_index(input logic [13:0] a);
        logic [13:0] m;
        m = a;
        if (a == 14'h3F10 || a == 14'h3F14 || a == 14'h3F18 || a == 14'h3F1C) begin
            m = a - PAL_MIRROR;
        end
        return m[12:0];
    endfunction

endpackage

@@ rtl/ppu_register_port_and_frame_timer.sv @@
`timescale 1ns / 1ps

// Register port and frame timer of a console picture processor. Each input
// beat is a register read, a register write or a tick of dot cycles (mode and
// register in tuser); each produces exactly one output beat with the read
// byte, nmi level, frame and line strobes, scanline and video address. Each
// item first has its beat registered and the OAM and video memories read,
// then updates state and loads the output register. No new beat is taken
// while an item is in processing, and a stalled output beat holds off the
// input. Sprite and video memory power up undefined.
module ppu_register_port_and_frame_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // write_data, dot_cycles, pattern_byte
    input  logic [23:0] s_axis_tdata,
    // mode, reg_select
    input  logic [4:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data, nmi_level, frame_done, draw_line, scanline, video_address,
    // unsupported, zero pad
    output logic [39:0] m_axis_tdata
);
    import ppurp_pkg::*;

    logic [1:0]  r_mode;
    logic [2:0]  r_sel;
    logic [7:0]  r_wd;
    logic [7:0]  r_dots;
    logic [7:0]  r_pat;
    logic        r_busy;
    logic        r_out_valid;
    t_result     r_out;

    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_mask, n_mask;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_oam_addr, n_oam_addr;
    logic [7:0]  r_scroll_h, n_scroll_h;
    logic [7:0]  r_scroll_v, n_scroll_v;
    logic        r_scroll_second, n_scroll_second;
    logic        r_addr_low, n_addr_low;
    logic [13:0] r_vaddr, n_vaddr;
    logic [7:0]  r_rbuf, n_rbuf;
    logic [9:0]  r_dot, n_dot;
    logic [8:0]  r_line, n_line;
    logic        r_nmi, n_nmi;
    logic [7:0]  r_oam_zero, n_oam_zero;
    t_result     n_out;

    logic [7:0]  r_oam_mem [256];
    logic [7:0]  r_vram_mem [8192];
    logic [7:0]  r_oam_q;
    logic [7:0]  r_vram_q;

    logic        oam_we;
    logic        vram_we;
    logic [12:0] vram_wa;
    logic [13:0] inc;
    logic [13:0] fa;
    logic [10:0] dot_sum;
    logic [9:0]  dot_sat;
    logic [8:0]  line_inc;
    logic        accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_busy && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out};

    assign inc      = r_ctrl[2] ? 14'd32 : 14'd1;
    assign fa       = fold_palette(r_vaddr);
    assign dot_sum  = {1'b0, r_dot} + {3'd0, r_dots};
    assign dot_sat  = dot_sum[10] ? 10'd1023 : dot_sum[9:0];
    assign line_inc = r_line + 9'd1;

    always_comb begin
        n_ctrl          = r_ctrl;
        n_mask          = r_mask;
        n_status        = r_status;
        n_oam_addr      = r_oam_addr;
        n_scroll_h      = r_scroll_h;
        n_scroll_v      = r_scroll_v;
        n_scroll_second = r_scroll_second;
        n_addr_low      = r_addr_low;
        n_vaddr         = r_vaddr;
        n_rbuf          = r_rbuf;
        n_dot           = r_dot;
        n_line          = r_line;
        n_nmi           = r_nmi;
        n_oam_zero      = r_oam_zero;
        oam_we          = 1'b0;
        vram_we         = 1'b0;
        vram_wa         = store_index(fa);
        n_out           = '0;
        case (r_mode)
            MODE_READ: begin
                case (r_sel)
                    REG_MASK: n_out.read_data = r_mask;
                    REG_STATUS: begin
                        n_out.read_data = r_status;
                        n_status        = {1'b0, r_status[6:0]};
                        n_scroll_second = 1'b0;
                        n_addr_low      = 1'b0;
                    end
                    REG_OAM_DATA: n_out.read_data = r_oam_q;
                    REG_DATA: begin
                        n_out.read_data = r_rbuf;
                        n_rbuf  = (r_vaddr < NAME_BASE) ? r_pat : r_vram_q;
                        n_vaddr = r_vaddr + inc;
                    end
                    default: n_out.unsupported = 1'b1;
                endcase
            end
            MODE_WRITE: begin
                case (r_sel)
                    REG_CTRL:     n_ctrl     = r_wd;
                    REG_MASK:     n_mask     = r_wd;
                    REG_STATUS:   n_status   = r_wd;
                    REG_OAM_ADDR: n_oam_addr = r_wd;
                    REG_OAM_DATA: begin
                        oam_we     = 1'b1;
                        n_oam_addr = r_oam_addr + 8'd1;
                        if (r_oam_addr == 8'd0) begin
                            n_oam_zero = r_wd;
                        end
                    end
                    REG_SCROLL: begin
                        if (!r_scroll_second) begin
                            n_scroll_h = r_wd;
                        end else begin
                            n_scroll_v = r_wd;
                        end
                        n_scroll_second = !r_scroll_second;
                    end
                    REG_ADDR: begin
                        if (!r_addr_low) begin
                            n_vaddr = {r_wd[5:0], 8'd0};
                        end else begin
                            n_vaddr = r_vaddr | {6'd0, r_wd};
                        end
                        n_addr_low = !r_addr_low;
                    end
                    default: begin
                        n_out.unsupported = (fa >= UNSUP_LO) && (fa <= UNSUP_HI);
                        vram_we           = (fa >= NAME_BASE);
                        n_vaddr           = fa + inc;
                    end
                endcase
            end
            MODE_TICK: begin
                n_dot = dot_sat;
                if (dot_sat >= DOTS_PER_LINE) begin
                    n_dot  = dot_sat - DOTS_PER_LINE;
                    n_line = line_inc;
                    if (line_inc >= SPRITE0_OFS &&
                        {1'b0, r_oam_zero} == line_inc - SPRITE0_OFS) begin
                        n_status[6] = 1'b1;
                    end
                    n_out.draw_line = (line_inc <= DRAW_LINE_MAX) &&
                                      (r_scroll_v <= SCROLL_V_MAX);
                    if (line_inc == VBLANK_LINE) begin
                        n_status[7] = 1'b1;
                        if (r_ctrl[7]) begin
                            n_nmi = 1'b1;
                        end
                    end
                    if (line_inc == LINES_PER_FRAME) begin
                        n_status[7:6]    = 2'b00;
                        n_nmi            = 1'b0;
                        n_line           = 9'd0;
                        n_out.frame_done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        n_out.nmi_level     = n_nmi;
        n_out.scanline      = n_line;
        n_out.video_address = n_vaddr;
    end

    always_ff @(posedge i_clk) begin
        r_oam_q  <= r_oam_mem[r_oam_addr];
        r_vram_q <= r_vram_mem[store_index(fa)];
        if (r_busy && oam_we) begin
            r_oam_mem[r_oam_addr] <= r_wd;
        end
        if (r_busy && vram_we) begin
            r_vram_mem[vram_wa] <= r_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= s_axis_tuser[1:0];
            r_sel   <= s_axis_tuser[4:2];
            r_wd    <= s_axis_tdata[7:0];
            r_dots  <= s_axis_tdata[15:8];
            r_pat   <= s_axis_tdata[23:16];
        end
        if (r_busy) begin
            r_out      <= n_out;
            r_oam_zero <= n_oam_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_out_valid     <= 1'b0;
            r_ctrl          <= '0;
            r_mask          <= '0;
            r_status        <= '0;
            r_oam_addr      <= '0;
            r_scroll_h      <= '0;
            r_scroll_v      <= '0;
            r_scroll_second <= 1'b0;
            r_addr_low      <= 1'b0;
            r_vaddr         <= '0;
            r_rbuf          <= '0;
            r_dot           <= '0;
            r_line          <= '0;
            r_nmi           <= 1'b0;
        end else begin
            r_busy <= accept;
            if (r_busy) begin
                r_out_valid     <= 1'b1;
                r_ctrl          <= n_ctrl;
                r_mask          <= n_mask;
                r_status        <= n_status;
                r_oam_addr      <= n_oam_addr;
                r_scroll_h      <= n_scroll_h;
                r_scroll_v      <= n_scroll_v;
                r_scroll_second <= n_scroll_second;
                r_addr_low      <= n_addr_low;
                r_vaddr         <= n_vaddr;
                r_rbuf          <= n_rbuf;
                r_dot           <= n_dot;
                r_line          <= n_line;
                r_nmi           <= n_nmi;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("item held in processing for more than one cycle");

    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_axis_tready)
        else $error("input taken while an item is in processing");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_out_valid)
        else $error("processed item produced no output beat");

    a_line_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line < LINES_PER_FRAME)
        else $error("scanline beyond end of frame");

endmodule
